>>> hw/rtl/tclc_pkg.sv
// shared types, constants and helper functions of the two-channel lux calculator
`default_nettype none

package tclc_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LUX_W      = 28;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned PATH_W     = PROD_W + 1;
  localparam int unsigned M_W        = 32;
  localparam int unsigned DF_W       = 16;
  localparam int unsigned NUM0_W     = M_W + DF_W;
  localparam int unsigned TIME_W     = 10;
  localparam int unsigned GAIN_W     = 14;
  localparam int unsigned DEN_BASE_W = 23;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  localparam logic [CNT_W-1:0] COUNT_FULL_SCALE = '1;
  localparam logic [LUX_W-1:0] LUX_MAX          = '1;

  localparam logic [GAIN_W-1:0] GAIN_TABLE [4] = '{
    GAIN_W'(1), GAIN_W'(25), GAIN_W'(428), GAIN_W'(9876)
  };

  typedef struct packed {
    logic [1:0]       gain_sel;
    logic [2:0]       int_sel;
    logic [DF_W-1:0]  device_factor;
    logic [CNT_W-1:0] coef_b;
    logic [CNT_W-1:0] coef_c;
    logic [CNT_W-1:0] coef_d;
  } cfg_t;

  // data that rides along with an item and is not part of the division
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] visible;
  } side_t;

  function automatic logic [TIME_W-1:0] time_ms(input logic [2:0] sel);
    logic [TIME_W-1:0] t;
    case (sel)
      3'd0:    t = TIME_W'(100);
      3'd1:    t = TIME_W'(200);
      3'd2:    t = TIME_W'(300);
      3'd3:    t = TIME_W'(400);
      3'd4:    t = TIME_W'(500);
      3'd5:    t = TIME_W'(600);
      default: t = TIME_W'(100);
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tclc_regs.sv
// configuration register file behind the apb-style port
`default_nettype none

module tclc_regs (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [tclc_pkg::ADDR_W-1:0]    paddr,
  input  wire  [tclc_pkg::DATA_W-1:0]    pwdata,
  output logic [tclc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output tclc_pkg::cfg_t                 cfg_o
);
  import tclc_pkg::*;

  localparam logic [2:0] REG_GAIN  = 3'd0;
  localparam logic [2:0] REG_INT   = 3'd1;
  localparam logic [2:0] REG_DF    = 3'd2;
  localparam logic [2:0] REG_COEFB = 3'd3;
  localparam logic [2:0] REG_COEFC = 3'd4;
  localparam logic [2:0] REG_COEFD = 3'd5;

  localparam cfg_t CFG_RESET = '{
    gain_sel:      2'd1,
    int_sel:       3'd0,
    device_factor: DF_W'(408),
    coef_b:        CNT_W'(6717),
    coef_c:        CNT_W'(2417),
    coef_d:        CNT_W'(3523)
  };

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN:  cfg_q.gain_sel      <= pwdata[1:0];
        REG_INT:   cfg_q.int_sel       <= pwdata[2:0];
        REG_DF:    cfg_q.device_factor <= pwdata[DF_W-1:0];
        REG_COEFB: cfg_q.coef_b        <= pwdata[CNT_W-1:0];
        REG_COEFC: cfg_q.coef_c        <= pwdata[CNT_W-1:0];
        REG_COEFD: cfg_q.coef_d        <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN:  prdata = DATA_W'(cfg_q.gain_sel);
      REG_INT:   prdata = DATA_W'(cfg_q.int_sel);
      REG_DF:    prdata = DATA_W'(cfg_q.device_factor);
      REG_COEFB: prdata = DATA_W'(cfg_q.coef_b);
      REG_COEFC: prdata = DATA_W'(cfg_q.coef_c);
      REG_COEFD: prdata = DATA_W'(cfg_q.coef_d);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/tclc_front.sv
// three-stage front end: channel products, path select, device factor scaling
`default_nettype none

module tclc_front #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  tclc_pkg::cfg_t                    cfg_i,
  input  wire                               in_valid_i,
  input  wire  [tclc_pkg::CNT_W-1:0]        full_i,
  input  wire  [tclc_pkg::CNT_W-1:0]        ir_i,
  output logic                              out_valid_o,
  output logic [tclc_pkg::NUM0_W-1:0]       num_o,
  output logic [tclc_pkg::DEN_BASE_W-1:0]   den_o,
  output tclc_pkg::side_t                   side_o
);
  import tclc_pkg::*;

  // stage a: products
  logic                  a_valid_q;
  logic [CNT_W-1:0]      a_full_q;
  logic [PROD_W-1:0]     a_bir_q, a_cfull_q, a_dir_q;
  logic                  a_zero_q;
  logic [DEN_BASE_W-1:0] a_den_q;
  side_t                 a_side_q;
  side_t                 a_side_d;
  logic                  a_zero_d;

  // stage b: larger path clamped
  logic                  b_valid_q;
  logic [M_W-1:0]        b_m_q;
  logic [DEN_BASE_W-1:0] b_den_q;
  side_t                 b_side_q;
  logic signed [PATH_W-1:0] p1, p2, best;
  logic [M_W-1:0]        b_m_d;

  // stage c: scaled numerator
  logic                  c_valid_q;
  logic [NUM0_W-1:0]     c_num_q;
  logic [DEN_BASE_W-1:0] c_den_q;
  side_t                 c_side_q;

  always_comb begin
    a_zero_d         = (full_i == COUNT_FULL_SCALE) || (ir_i == COUNT_FULL_SCALE)
                       || (full_i == '0);
    a_side_d.ok      = (full_i != COUNT_FULL_SCALE) && (ir_i != COUNT_FULL_SCALE);
    a_side_d.visible = (full_i >= ir_i) ? CNT_W'(full_i - ir_i) : '0;
  end

  always_comb begin
    p1    = $signed(PATH_W'(PATH_W'(a_full_q) << COEF_FRAC_BITS)) - $signed(PATH_W'(a_bir_q));
    p2    = $signed(PATH_W'(a_cfull_q)) - $signed(PATH_W'(a_dir_q));
    best  = (p1 > p2) ? p1 : p2;
    b_m_d = (a_zero_q || best <= 0) ? '0 : best[M_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_full_q  <= full_i;
    a_bir_q   <= cfg_i.coef_b * ir_i;
    a_cfull_q <= cfg_i.coef_c * full_i;
    a_dir_q   <= cfg_i.coef_d * ir_i;
    a_zero_q  <= a_zero_d;
    a_den_q   <= DEN_BASE_W'(time_ms(cfg_i.int_sel)) * DEN_BASE_W'(GAIN_TABLE[cfg_i.gain_sel]);
    a_side_q  <= a_side_d;

    b_m_q     <= b_m_d;
    b_den_q   <= a_den_q;
    b_side_q  <= a_side_q;

    c_num_q   <= b_m_q * cfg_i.device_factor;
    c_den_q   <= b_den_q;
    c_side_q  <= b_side_q;
  end

  assign out_valid_o = c_valid_q;
  assign num_o       = c_num_q;
  assign den_o       = c_den_q;
  assign side_o      = c_side_q;

endmodule

`default_nettype wire

>>> hw/rtl/tclc_div_cell.sv
// one restoring-division cell: decides one quotient bit and passes the remainder on
`default_nettype none

module tclc_div_cell #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 27,
  parameter int unsigned Q_W   = 29,
  parameter int unsigned BIT   = 0
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     valid_i,
  input  wire  [NUM_W-1:0]        rem_i,
  input  wire  [DEN_W-1:0]        den_i,
  input  wire  [Q_W-1:0]          q_i,
  input  tclc_pkg::side_t         side_i,
  output logic                    valid_o,
  output logic [NUM_W-1:0]        rem_o,
  output logic [DEN_W-1:0]        den_o,
  output logic [Q_W-1:0]          q_o,
  output tclc_pkg::side_t         side_o
);
  import tclc_pkg::*;

  localparam int unsigned CMP_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic                 valid_q;
  logic [NUM_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q;
  logic [Q_W-1:0]       q_q, q_d;
  side_t                side_q;
  logic [CMP_W-1:0]     den_sh, rem_ext, diff;
  logic                 ge;

  always_comb begin
    den_sh  = CMP_W'(den_i) << BIT;
    rem_ext = CMP_W'(rem_i);
    diff    = rem_ext - den_sh;
    ge      = rem_ext >= den_sh;
    rem_d   = ge ? diff[NUM_W-1:0] : rem_i;
    q_d     = q_i;
    q_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_i;
    q_q    <= q_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> hw/rtl/two_channel_lux_calculator_top.sv
// top level of the two-channel lux calculator
`default_nettype none

// Two-channel lux calculator. A word (full-spectrum and infrared count) is taken
// at every clock edge with start high; busy never rises, so one word per cycle is
// sustained. Each word yields exactly one result, shown for one
// cycle with done_o high; the receiver cannot stall, so it must take every result.
// The pipeline is three front stages (channel products, path select and clamp,
// device factor scaling) plus a row of 29 division cells, one quotient bit each,
// the top one detecting saturation. Visible count and the valid flag travel
// alongside the division. Configuration registers sit on the apb-style port at
// byte address 4*i and must be written only while no word is in flight.
module two_channel_lux_calculator_top #(
  parameter int unsigned COEF_FRAC_BITS = 12,
  parameter int unsigned LUX_FRAC_BITS  = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // apb-style configuration port
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [tclc_pkg::ADDR_W-1:0]     paddr,
  input  wire  [tclc_pkg::DATA_W-1:0]     pwdata,
  output logic [tclc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // input word
  input  wire                             start,
  output logic                            busy,
  input  wire  [tclc_pkg::CNT_W-1:0]      full_count_i,
  input  wire  [tclc_pkg::CNT_W-1:0]      ir_count_i,
  // result word
  output logic                            done_o,
  output logic [tclc_pkg::LUX_W-1:0]      lux_value_o,
  output logic                            lux_valid_o,
  output logic [tclc_pkg::CNT_W-1:0]      visible_count_o
);
  import tclc_pkg::*;

  // scaling by 2^(lux_frac - coef_frac) goes on the numerator or the divisor
  localparam int unsigned SH_NUM = (LUX_FRAC_BITS >= COEF_FRAC_BITS) ?
                                   LUX_FRAC_BITS - COEF_FRAC_BITS : 0;
  localparam int unsigned SH_DEN = (LUX_FRAC_BITS >= COEF_FRAC_BITS) ?
                                   0 : COEF_FRAC_BITS - LUX_FRAC_BITS;
  localparam int unsigned NUM_W  = NUM0_W + SH_NUM;
  localparam int unsigned DEN_W  = DEN_BASE_W + SH_DEN;
  // one extra quotient bit on top flags results past the lux range
  localparam int unsigned Q_W    = LUX_W + 1;

  cfg_t                  cfg;
  logic                  accept;
  logic                  fe_valid;
  logic [NUM0_W-1:0]     fe_num;
  logic [DEN_BASE_W-1:0] fe_den;
  side_t                 fe_side;

  // chain links: index 0 feeds the first cell, index Q_W leaves the last
  logic                  ch_valid [Q_W+1];
  logic [NUM_W-1:0]      ch_rem   [Q_W+1];
  logic [DEN_W-1:0]      ch_den   [Q_W+1];
  logic [Q_W-1:0]        ch_q     [Q_W+1];
  side_t                 ch_side  [Q_W+1];

  // the pipeline takes a word every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tclc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // products, larger path, times device factor; forced to zero on overflow, dark or no positive path
  tclc_front #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (accept),
    .full_i      (full_count_i),
    .ir_i        (ir_count_i),
    .out_valid_o (fe_valid),
    .num_o       (fe_num),
    .den_o       (fe_den),
    .side_o      (fe_side)
  );

  assign ch_valid[0] = fe_valid;
  assign ch_rem[0]   = NUM_W'(NUM_W'(fe_num) << SH_NUM);
  assign ch_den[0]   = DEN_W'(DEN_W'(fe_den) << SH_DEN);
  assign ch_q[0]     = '0;
  assign ch_side[0]  = fe_side;

  // restoring divider, most significant quotient bit first
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    tclc_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (Q_W),
      .BIT   (Q_W - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[i]),
      .rem_i   (ch_rem[i]),
      .den_i   (ch_den[i]),
      .q_i     (ch_q[i]),
      .side_i  (ch_side[i]),
      .valid_o (ch_valid[i+1]),
      .rem_o   (ch_rem[i+1]),
      .den_o   (ch_den[i+1]),
      .q_o     (ch_q[i+1]),
      .side_o  (ch_side[i+1])
    );
  end

  // saturate when the quotient reaches 2^LUX_W; lower bits are then meaningless
  assign done_o          = ch_valid[Q_W];
  assign lux_value_o     = ch_q[Q_W][Q_W-1] ? LUX_MAX : ch_q[Q_W][LUX_W-1:0];
  assign lux_valid_o     = ch_side[Q_W].ok;
  assign visible_count_o = ch_side[Q_W].visible;

endmodule

`default_nettype wire

>>> sim/tb.sv
// self-checking testbench of the two-channel lux calculator
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point formats of the block, default parameters
  localparam int unsigned COEF_FRAC     = 12;
  localparam int unsigned LUX_FRAC      = 8;
  localparam logic [27:0] LUX_TOP       = 28'hFFFFFFF;
  localparam logic [15:0] COUNT_SAT     = 16'hFFFF;
  // stimulus and run control
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 145;
  localparam int unsigned STEADY_PHASE  = 3;
  localparam int unsigned IDLE_PERCENT  = 18;
  // the tail and the stall limit leave ample margin for a result to come out
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef longint unsigned u64_t;

  // register map, word index i sits at byte address 4*i
  typedef enum int unsigned {
    REG_GAIN_SEL      = 0,
    REG_INT_SEL       = 1,
    REG_DEVICE_FACTOR = 2,
    REG_COEF_B        = 3,
    REG_COEF_C        = 4,
    REG_COEF_D        = 5,
    REG_SPARE_A       = 6,
    REG_SPARE_B       = 7
  } reg_index_e;

  typedef struct {
    logic [1:0]  gain_sel;
    logic [2:0]  int_sel;
    logic [15:0] device_factor;
    logic [15:0] coef_b;
    logic [15:0] coef_c;
    logic [15:0] coef_d;
  } sensor_settings_t;

  typedef struct {
    logic [27:0] lux;
    logic        valid;
    logic [15:0] visible;
  } lux_reading_t;

  localparam sensor_settings_t POWER_ON_SETTINGS = '{
    gain_sel: 2'd1, int_sel: 3'd0, device_factor: 16'd408,
    coef_b: 16'd6717, coef_c: 16'd2417, coef_d: 16'd3523
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [tclc_pkg::ADDR_W-1:0]         paddr;
  logic [tclc_pkg::DATA_W-1:0]         pwdata;
  logic [tclc_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  logic                                start;
  logic                                busy;
  logic [tclc_pkg::CNT_W-1:0]          full_count_i;
  logic [tclc_pkg::CNT_W-1:0]          ir_count_i;

  logic                                done_o;
  logic [tclc_pkg::LUX_W-1:0]          lux_value_o;
  logic                                lux_valid_o;
  logic [tclc_pkg::CNT_W-1:0]          visible_count_o;

  // predictor's copy of the register file
  sensor_settings_t sensor_cfg = POWER_ON_SETTINGS;
  // readings predicted for words accepted, oldest first
  lux_reading_t     pending_readings[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned readings_seen  = 0;
  // no input gaps while this is set
  bit          steady_flow    = 1'b0;

  two_channel_lux_calculator_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .full_count_i    (full_count_i),
    .ir_count_i      (ir_count_i),
    .done_o          (done_o),
    .lux_value_o     (lux_value_o),
    .lux_valid_o     (lux_valid_o),
    .visible_count_o (visible_count_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic u64_t gain_of(input logic [1:0] sel);
    case (sel)
      2'd0:    return 64'd1;
      2'd1:    return 64'd25;
      2'd2:    return 64'd428;
      default: return 64'd9876;
    endcase
  endfunction

  // integration time in ms, codes above 5 fall back to 100 ms
  function automatic u64_t integration_ms(input logic [2:0] sel);
    if (sel <= 3'd5) begin
      return (u64_t'(sel) + 64'd1) * 64'd100;
    end
    return 64'd100;
  endfunction

  function automatic lux_reading_t predict_reading(input logic [15:0] full,
                                                   input logic [15:0] ir);
    lux_reading_t r;
    longint       path_a;
    longint       path_b;
    longint       best;
    u64_t         num;
    u64_t         den;
    u64_t         quot;
    r.visible = (full >= ir) ? full - ir : 16'd0;
    r.valid   = 1'b1;
    r.lux     = '0;
    if (full == COUNT_SAT || ir == COUNT_SAT) begin
      // channel overflow: lux forced to zero and flagged invalid
      r.valid = 1'b0;
    end else if (full != 16'd0) begin
      // both paths exact in the coefficient format
      path_a = (longint'(full) <<< COEF_FRAC) - longint'(sensor_cfg.coef_b) * longint'(ir);
      path_b = longint'(sensor_cfg.coef_c) * longint'(full)
             - longint'(sensor_cfg.coef_d) * longint'(ir);
      best   = (path_a > path_b) ? path_a : path_b;
      if (best > 0) begin
        num = u64_t'(best) * u64_t'(sensor_cfg.device_factor);
        den = integration_ms(sensor_cfg.int_sel) * gain_of(sensor_cfg.gain_sel);
        if (LUX_FRAC >= COEF_FRAC) begin
          num = num << (LUX_FRAC - COEF_FRAC);
        end else begin
          den = den << (COEF_FRAC - LUX_FRAC);
        end
        quot = num / den;
        if (quot > u64_t'(LUX_TOP)) begin
          quot = u64_t'(LUX_TOP);
        end
        r.lux = quot[27:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] register_value(input reg_index_e idx);
    case (idx)
      REG_GAIN_SEL:      return 32'(sensor_cfg.gain_sel);
      REG_INT_SEL:       return 32'(sensor_cfg.int_sel);
      REG_DEVICE_FACTOR: return 32'(sensor_cfg.device_factor);
      REG_COEF_B:        return 32'(sensor_cfg.coef_b);
      REG_COEF_C:        return 32'(sensor_cfg.coef_c);
      REG_COEF_D:        return 32'(sensor_cfg.coef_d);
      default:           return 32'd0;
    endcase
  endfunction

  // one apb transfer; psel stays up so transfers can follow back to back
  task automatic bus_transfer(input reg_index_e idx, input logic is_write,
                              input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= tclc_pkg::ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic bus_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(input reg_index_e idx, input logic [31:0] data);
    logic [31:0] unused;
    bus_transfer(idx, 1'b1, data, unused);
    case (idx)
      REG_GAIN_SEL:      sensor_cfg.gain_sel      = data[1:0];
      REG_INT_SEL:       sensor_cfg.int_sel       = data[2:0];
      REG_DEVICE_FACTOR: sensor_cfg.device_factor = data[15:0];
      REG_COEF_B:        sensor_cfg.coef_b        = data[15:0];
      REG_COEF_C:        sensor_cfg.coef_c        = data[15:0];
      REG_COEF_D:        sensor_cfg.coef_d        = data[15:0];
      default: ;  // unmapped index, write dropped
    endcase
  endtask

  task automatic report_mismatch(input string what, input u64_t got, input u64_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // read back every mapped register against the predictor's copy
  task automatic check_registers();
    logic [31:0] rdata;
    for (int i = REG_GAIN_SEL; i <= REG_COEF_D; i++) begin
      bus_transfer(reg_index_e'(i), 1'b0, 32'd0, rdata);
      if (rdata != register_value(reg_index_e'(i))) begin
        report_mismatch($sformatf("register %0d readback", i),
                        u64_t'(rdata), u64_t'(register_value(reg_index_e'(i))));
      end
    end
    bus_release();
  endtask

  // ---------------------------------------------------------------------------
  // input words
  // ---------------------------------------------------------------------------

  // let every word in flight come out; every word yields a result, so an
  // empty queue means an empty pipeline
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic load_settings(input sensor_settings_t s, input logic [15:0] upper);
    drain_results();
    // upper bits of each write carry junk that the block must drop
    write_register(REG_GAIN_SEL,      {upper, 14'd0, s.gain_sel});
    write_register(REG_INT_SEL,       {upper, 13'd0, s.int_sel});
    write_register(REG_DEVICE_FACTOR, {upper, s.device_factor});
    write_register(REG_COEF_B,        {upper, s.coef_b});
    write_register(REG_COEF_C,        {upper, s.coef_c});
    write_register(REG_COEF_D,        {upper, s.coef_d});
    bus_release();
    check_registers();
  endtask

  task automatic send_counts(input logic [15:0] full, input logic [15:0] ir);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    full_count_i <= full;
    ir_count_i   <= ir;
    do @(posedge clk_i); while (busy);
    pending_readings.push_back(predict_reading(full, ir));
  endtask

  // mostly plausible sensor readings, with extremes and noise mixed in
  task automatic pick_counts(output logic [15:0] full, output logic [15:0] ir);
    int unsigned kind;
    int unsigned scaled;
    kind = $urandom_range(9);
    full = 16'($urandom);
    ir   = 16'($urandom);
    case (kind)
      1, 2, 3, 4: begin
        // infrared as a fraction of full spectrum, sometimes above it
        scaled = (int'(full) * $urandom_range(300)) >> 8;
        ir     = (scaled > 65534) ? 16'd65534 : 16'(scaled);
      end
      5: begin
        full = 16'($urandom_range(255));
        ir   = 16'($urandom_range(255));
      end
      6: begin
        case ($urandom_range(3))
          0:       full = 16'd0;
          1:       full = 16'd1;
          2:       full = 16'd65534;
          default: full = COUNT_SAT;
        endcase
      end
      7: begin
        case ($urandom_range(3))
          0:       ir = 16'd0;
          1:       ir = 16'd1;
          2:       ir = 16'd65534;
          default: ir = COUNT_SAT;
        endcase
      end
      default: ;  // both fields fully random
    endcase
  endtask

  function automatic logic [15:0] draw_coef(input logic [15:0] usual);
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return usual;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sensor_settings_t draw_settings();
    sensor_settings_t s;
    s.gain_sel = 2'($urandom_range(3));
    s.int_sel  = 3'($urandom_range(7));
    case ($urandom_range(7))
      0:       s.device_factor = 16'd0;
      1:       s.device_factor = 16'd1;
      2:       s.device_factor = 16'hFFFF;
      3:       s.device_factor = 16'd408;
      default: s.device_factor = 16'($urandom_range(65535, 1));
    endcase
    s.coef_b = draw_coef(POWER_ON_SETTINGS.coef_b);
    s.coef_c = draw_coef(POWER_ON_SETTINGS.coef_c);
    s.coef_d = draw_coef(POWER_ON_SETTINGS.coef_d);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of the registers and the corner readings under them
  task automatic test_reset_settings();
    check_registers();
    send_counts(16'd0,     16'd0);      // dark reading
    send_counts(16'd0,     16'd1234);   // dark reading, infrared present
    send_counts(16'd1,     16'd0);
    send_counts(COUNT_SAT, 16'd0);      // full-spectrum overflow
    send_counts(16'd0,     COUNT_SAT);  // infrared overflow
    send_counts(COUNT_SAT, COUNT_SAT);
    send_counts(16'd65534, 16'd0);      // largest valid count
    send_counts(16'd65534, 16'd65534);
    send_counts(16'd300,   16'd600);    // both paths negative
    send_counts(16'd1000,  16'd100);
    send_counts(16'd40000, 16'd12000);
    send_counts(16'hAAAA,  16'h5555);
  endtask

  // register extremes: saturation, smallest result, fallback time codes,
  // zero device factor and unmapped register writes
  task automatic test_register_extremes();
    sensor_settings_t s;
    s = '{gain_sel: 2'd0, int_sel: 3'd0, device_factor: 16'hFFFF,
          coef_b: 16'd0, coef_c: 16'hFFFF, coef_d: 16'd0};
    load_settings(s, 16'hFFFF);
    send_counts(16'd65534, 16'd0);      // saturates at the lux maximum
    send_counts(16'd1,     16'd0);

    s = '{gain_sel: 2'd3, int_sel: 3'd5, device_factor: 16'd1,
          coef_b: 16'hFFFF, coef_c: 16'd0, coef_d: 16'hFFFF};
    load_settings(s, 16'h0000);
    send_counts(16'd65534, 16'd1);
    send_counts(16'd1,     16'd0);
    send_counts(16'd100,   16'd65534);

    s = POWER_ON_SETTINGS;
    s.gain_sel = 2'd2;
    s.int_sel  = 3'd6;                  // unused code, acts as 100 ms
    load_settings(s, 16'h5A5A);
    send_counts(16'd5000, 16'd1000);
    s.int_sel  = 3'd7;
    load_settings(s, 16'hA5A5);
    send_counts(16'd5000, 16'd1000);

    s.device_factor = 16'd0;
    load_settings(s, 16'd0);
    send_counts(16'd5000, 16'd10);

    // writes to unmapped indexes leave the register file alone
    s.device_factor = 16'd408;
    load_settings(s, 16'd0);
    drain_results();
    write_register(REG_SPARE_A, $urandom);
    write_register(REG_SPARE_B, $urandom);
    bus_release();
    check_registers();
    send_counts(16'd5000, 16'd1000);
  endtask

  // random settings per phase, random words in between, one phase without gaps
  task automatic test_random_traffic();
    logic [15:0] full;
    logic [15:0] ir;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_settings(draw_settings(), 16'($urandom));
      if ($urandom_range(3) == 0) begin
        drain_results();
        write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        bus_release();
      end
      steady_flow = (phase == STEADY_PHASE);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick_counts(full, ir);
        send_counts(full, ir);
      end
      steady_flow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking: every done_o cycle carries one word, no back-pressure
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_readings
    lux_reading_t want;
    if (rst_ni && done_o) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result word, lux_value", u64_t'(lux_value_o), 64'd0);
      end else begin
        want = pending_readings.pop_front();
        if (lux_value_o !== want.lux) begin
          report_mismatch($sformatf("result %0d lux_value", readings_seen),
                          u64_t'(lux_value_o), u64_t'(want.lux));
        end
        if (lux_valid_o !== want.valid) begin
          report_mismatch($sformatf("result %0d lux_valid", readings_seen),
                          u64_t'(lux_valid_o), u64_t'(want.valid));
        end
        if (visible_count_o !== want.visible) begin
          report_mismatch($sformatf("result %0d visible_count", readings_seen),
                          u64_t'(visible_count_o), u64_t'(want.visible));
        end
      end
    end
  end

  // watchdog: too many cycles in a row without any word or register transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    start        <= 1'b0;
    full_count_i <= '0;
    ir_count_i   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_register_extremes();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
